[src/acceleration_split_timer_core_assert.svh]
// assertion macros for the acceleration split timer
// expect signals named clk and rst_n in the scope of use
`ifndef ACCELERATION_SPLIT_TIMER_CORE_ASSERT_SVH
`define ACCELERATION_SPLIT_TIMER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define AST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ast_pkg.sv]
// shared constants and types of the acceleration split timer
// no dependencies
`timescale 1ns / 1ps

package ast_pkg;

  localparam int AST_MARK_COUNT = 6;   // default number of speed marks
  localparam int AST_MARK_REGS  = 6;   // mark registers and split outputs

  localparam int AST_SPEED_W = 16;
  localparam int AST_TIME_W  = 32;
  localparam int AST_SPLIT_W = 16;
  localparam int AST_MARK_W  = 8;
  localparam int AST_SATS_W  = 5;
  localparam int AST_PHASE_W = 3;
  localparam int AST_CFG_IDX_W = 3;
  localparam int AST_CFG_DATA_W = 8;
  localparam int AST_THR_W   = 12;     // mark times scale

  localparam logic [AST_TIME_W-1:0] AST_RACE_LIMIT_MS = 32'd60000;
  localparam logic [AST_SATS_W-1:0] AST_MIN_SATS      = 5'd4;
  localparam logic [AST_THR_W-1:0]  AST_MARK_SCALE    = 12'd10;

  // operation codes
  localparam logic AST_OP_FIX     = 1'b0;
  localparam logic AST_OP_RESTART = 1'b1;

  // configuration register indexes
  localparam logic [AST_CFG_IDX_W-1:0] AST_CFG_ENABLE = 3'd0;
  localparam logic [AST_CFG_IDX_W-1:0] AST_CFG_MARK_0 = 3'd1;

  typedef logic [AST_SPLIT_W-1:0] split_t;

  typedef struct packed {
    logic [AST_PHASE_W-1:0]          phase;
    logic                            display_update;
    split_t [AST_MARK_REGS-1:0]      split_time;
  } result_t;

endpackage

[src/ast_if.sv]
// item channels of the acceleration split timer
// depends on ast_pkg
`timescale 1ns / 1ps

interface ast_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [ast_pkg::AST_SATS_W-1:0]    satellites;
  logic [ast_pkg::AST_SPEED_W-1:0]   speed;
  logic [ast_pkg::AST_TIME_W-1:0]    now_ms;

  modport source(output valid, operation, satellites, speed, now_ms, input ready);
  modport sink(input valid, operation, satellites, speed, now_ms, output ready);
endinterface

interface ast_out_if;
  logic                              valid;
  logic                              ready;
  logic [ast_pkg::AST_PHASE_W-1:0]   phase;
  logic                              display_update;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_0;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_1;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_2;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_3;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_4;
  logic [ast_pkg::AST_SPLIT_W-1:0]   split_time_5;

  modport source(output valid, phase, display_update, split_time_0, split_time_1,
                 split_time_2, split_time_3, split_time_4, split_time_5, input ready);
  modport sink(input valid, phase, display_update, split_time_0, split_time_1,
               split_time_2, split_time_3, split_time_4, split_time_5, output ready);
endinterface

[src/acceleration_split_timer_core.sv]
// acceleration split timer: phase tracking and per-mark split latching
// depends on ast_pkg, ast_if.sv and acceleration_split_timer_core_assert.svh
`timescale 1ns / 1ps
//
// usage
//   in_ch carries one gps fix or restart command per item; out_ch returns one
//   result item (phase, display_update, six split times) per input item.
//   cfg_we/cfg_index/cfg_wdata write enable (index 0) and the six speed marks
//   (indexes 1..6); other indexes are dropped. write only while idle.
// timing
//   an item is evaluated in the cycle it is accepted; its result goes to the
//   output slot, or to the skid slot while out_ch holds the output. one item
//   per cycle while out_ch takes results; each item builds on the last's state.
// stall
//   the output register is backed by a one-item skid stage, so an item is
//   still taken while a result waits; in_ch.ready drops only when both hold.
// reset
//   rst_n clears phase to awaiting, the start stamp and splits to zero, the
//   registers to zero and both output slots to empty.
//
module acceleration_split_timer_core #(
  parameter int MARK_COUNT = ast_pkg::AST_MARK_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ast_in_if.sink                               in_ch,
  ast_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [ast_pkg::AST_CFG_IDX_W-1:0]    cfg_index,
  input  logic [ast_pkg::AST_CFG_DATA_W-1:0]   cfg_wdata
);

  `include "acceleration_split_timer_core_assert.svh"

  // marks beyond the register list are never visible, so only the visible
  // ones are stored
  localparam int NUM_SPLIT = (MARK_COUNT > ast_pkg::AST_MARK_REGS) ?
                             ast_pkg::AST_MARK_REGS : MARK_COUNT;

  typedef enum logic [ast_pkg::AST_PHASE_W-1:0] {
    PH_AWAIT = 3'd0,
    PH_IDLE  = 3'd1,
    PH_SOFT  = 3'd2,
    PH_RACE  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // configuration
  logic                                enable_r;
  logic [ast_pkg::AST_MARK_W-1:0]      mark_r [ast_pkg::AST_MARK_REGS];

  // measurement state
  phase_t                              phase_r, phase_nxt;
  logic [ast_pkg::AST_TIME_W-1:0]      stamp_r, stamp_nxt;
  ast_pkg::split_t                     split_r   [NUM_SPLIT];
  ast_pkg::split_t                     split_nxt [NUM_SPLIT];
  logic                                upd;

  // output slot and skid slot
  logic                                out_v_r, skid_v_r;
  ast_pkg::result_t                    out_d_r, skid_d_r;
  ast_pkg::result_t                    res;

  logic                                in_fire, out_free;
  logic                                restart_fire;
  logic [ast_pkg::AST_TIME_W-1:0]      elapsed;
  logic                                fix_ok;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = !skid_v_r;
  assign restart_fire = in_fire && (in_ch.operation == ast_pkg::AST_OP_RESTART);

  // elapsed time wraps with the millisecond clock
  assign elapsed = in_ch.now_ms - stamp_r;
  assign fix_ok  = enable_r && (in_ch.satellites >= ast_pkg::AST_MIN_SATS);

  // one pass over the item: restart clear or phase step, plus the race-fix latch
  always_comb begin
    logic race;
    logic clear;
    logic [ast_pkg::AST_THR_W-1:0] thr;
    race      = 1'b0;
    clear     = 1'b0;
    thr       = '0;
    phase_nxt = phase_r;
    stamp_nxt = stamp_r;
    upd       = 1'b0;
    for (int i = 0; i < NUM_SPLIT; i++) begin
      split_nxt[i] = split_r[i];
    end

    if (in_ch.operation == ast_pkg::AST_OP_RESTART) begin
      clear = 1'b1;
      upd   = 1'b1;
    end else if (fix_ok) begin
      upd = 1'b1;
      case (phase_r)
        PH_AWAIT: begin
          if (in_ch.speed == '0) phase_nxt = PH_IDLE;
        end
        PH_IDLE: begin
          if (in_ch.speed != '0) begin
            phase_nxt = PH_SOFT;
            stamp_nxt = in_ch.now_ms;
          end
        end
        PH_SOFT: begin
          // a stop before the race starts throws the run away
          if (in_ch.speed == '0) begin
            clear = 1'b1;
          end else begin
            phase_nxt = PH_RACE;
            race      = 1'b1;
          end
        end
        PH_RACE: begin
          if (in_ch.speed == '0) phase_nxt = PH_DONE;
          else                   race      = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (race) begin
      // a zero split still reads as not reached and may latch again
      for (int i = 0; i < NUM_SPLIT; i++) begin
        thr = mark_r[i] * ast_pkg::AST_MARK_SCALE;
        if (split_r[i] == '0 && in_ch.speed >= ast_pkg::AST_SPEED_W'(thr)) begin
          split_nxt[i] = elapsed[ast_pkg::AST_SPLIT_W-1:0];
        end
      end
      if (elapsed >= ast_pkg::AST_RACE_LIMIT_MS) phase_nxt = PH_DONE;
    end

    if (clear) begin
      phase_nxt = PH_AWAIT;
      stamp_nxt = '0;
      for (int i = 0; i < NUM_SPLIT; i++) begin
        split_nxt[i] = '0;
      end
    end
  end

  // result item built from the state after this item
  always_comb begin
    res.phase          = phase_nxt;
    res.display_update = upd;
    for (int j = 0; j < ast_pkg::AST_MARK_REGS; j++) begin
      res.split_time[j] = '0;
    end
    for (int j = 0; j < NUM_SPLIT; j++) begin
      res.split_time[j] = split_nxt[j];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int k = 0; k < ast_pkg::AST_MARK_REGS; k++) begin
        mark_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == ast_pkg::AST_CFG_ENABLE) enable_r <= cfg_wdata[0];
      for (int k = 0; k < ast_pkg::AST_MARK_REGS; k++) begin
        if (cfg_index == ast_pkg::AST_CFG_MARK_0 + ast_pkg::AST_CFG_IDX_W'(k)) begin
          mark_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // phase, start stamp and split store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      stamp_r <= '0;
      for (int i = 0; i < NUM_SPLIT; i++) begin
        split_r[i] <= '0;
      end
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_nxt;
      for (int i = 0; i < NUM_SPLIT; i++) begin
        split_r[i] <= split_nxt[i];
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : res;
    end
    if (!out_free && in_fire) begin
      skid_d_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.phase          = out_d_r.phase;
  assign out_ch.display_update = out_d_r.display_update;
  assign out_ch.split_time_0   = out_d_r.split_time[0];
  assign out_ch.split_time_1   = out_d_r.split_time[1];
  assign out_ch.split_time_2   = out_d_r.split_time[2];
  assign out_ch.split_time_3   = out_d_r.split_time[3];
  assign out_ch.split_time_4   = out_d_r.split_time[4];
  assign out_ch.split_time_5   = out_d_r.split_time[5];

  // skid slot only fills behind a held output
  `AST_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r, "skid full with output empty")
  // a restart always lands in awaiting
  `AST_ASSERT_NEXT(a_restart_clears, restart_fire, phase_r == PH_AWAIT, "restart missed")
  // done is left only through a restart
  `AST_ASSERT_NEXT(a_done_sticks, phase_r == PH_DONE && !restart_fire, phase_r == PH_DONE, "done left")
  // awaiting is only reached by a clear or by reset, so no stamp is held there
  `AST_ASSERT_NOW(a_await_no_stamp, phase_r == PH_AWAIT, stamp_r == '0, "stamp held while awaiting")

endmodule
